// ----- design/tmfa_pkg.sv -----
`timescale 1ns / 1ps
package tmfa_pkg;
  localparam int COORD_BITS_DEF = 12;
  localparam int AREA_BITS      = 26;
  localparam logic [AREA_BITS-1:0] AREA_MAX = {AREA_BITS{1'b1}};
  localparam int ADDR_BITS      = 3;
  // register index as decoded from paddr[2]
  localparam logic REG_TOLERANCE = 1'b0;
  localparam int N_FACES        = 4;
  localparam int N_VERTS        = 4;
endpackage

// ----- design/tetrahedron_min_face_area_unit.sv -----
`timescale 1ns / 1ps
// Smallest face of a tetrahedron, in twice-area units: floor(sqrt(|(Q-P)x(R-P)|^2)) per face,
// saturated to 26 bits, faces taken as (0,1,2),(1,2,3),(2,3,0),(3,0,1); a later face replaces
// the running minimum only when it undercuts it by more than the tolerance register (byte
// address 0). One transaction is accepted per cycle while the output is not stalled. The
// restoring square root pipeline has ROOTW = 2*COORD_BITS+4 one-bit stages (28 at 12-bit
// coordinates). A stalled output holds the whole pipeline.
module tetrahedron_min_face_area_unit
  import tmfa_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_a_x,
  input  logic signed [COORD_BITS-1:0] in_a_y,
  input  logic signed [COORD_BITS-1:0] in_a_z,
  input  logic signed [COORD_BITS-1:0] in_b_x,
  input  logic signed [COORD_BITS-1:0] in_b_y,
  input  logic signed [COORD_BITS-1:0] in_b_z,
  input  logic signed [COORD_BITS-1:0] in_c_x,
  input  logic signed [COORD_BITS-1:0] in_c_y,
  input  logic signed [COORD_BITS-1:0] in_c_z,
  input  logic signed [COORD_BITS-1:0] in_d_x,
  input  logic signed [COORD_BITS-1:0] in_d_y,
  input  logic signed [COORD_BITS-1:0] in_d_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic        [AREA_BITS-1:0]  out_min_double_area,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic        [ADDR_BITS-1:0]  paddr,
  input  logic        [31:0]           pwdata,
  output logic        [31:0]           prdata,
  output logic                         pready
);
  localparam int CW    = 2 * (COORD_BITS + 1) + 1;
  localparam int SUMW  = 2 * CW + 2;
  localparam int ROOTW = SUMW / 2;

  logic                         en;
  logic [AREA_BITS-1:0]         tol_r;
  logic signed [COORD_BITS-1:0] pts [N_VERTS][3];
  logic                         face_vld;
  logic [SUMW-1:0]              norm2 [N_FACES];
  logic                         root_vld;
  logic [ROOTW-1:0]             root [N_FACES];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign pready   = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_TOLERANCE)) begin
      tol_r <= pwdata[AREA_BITS-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_TOLERANCE) ? 32'(tol_r) : 32'd0;

  always_comb begin
    pts[0][0] = in_a_x; pts[0][1] = in_a_y; pts[0][2] = in_a_z;
    pts[1][0] = in_b_x; pts[1][1] = in_b_y; pts[1][2] = in_b_z;
    pts[2][0] = in_c_x; pts[2][1] = in_c_y; pts[2][2] = in_c_z;
    pts[3][0] = in_d_x; pts[3][1] = in_d_y; pts[3][2] = in_d_z;
  end

  tmfa_faces #(.COORD_BITS(COORD_BITS), .SUMW(SUMW)) u_faces (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(in_valid && in_ready),
    .pts(pts), .out_vld(face_vld), .norm2(norm2)
  );

  tmfa_sqrt #(.SUMW(SUMW), .ROOTW(ROOTW)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(face_vld),
    .n_in(norm2), .out_vld(root_vld), .root(root)
  );

  tmfa_min #(.ROOTW(ROOTW)) u_min (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(root_vld),
    .root(root), .tol(tol_r), .out_vld(out_valid), .best(out_min_double_area)
  );
endmodule

// ----- design/tmfa_faces.sv -----
`timescale 1ns / 1ps
module tmfa_faces
  import tmfa_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int SUMW       = 2 * (2 * COORD_BITS + 3) + 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic signed [COORD_BITS-1:0] pts [N_VERTS][3],
  output logic                         out_vld,
  output logic        [SUMW-1:0]       norm2 [N_FACES]
);
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int CW = PW + 1;
  localparam int SQW = 2 * CW;

  logic               vld_r [5];
  logic signed [DW-1:0] u_r [N_FACES][3];
  logic signed [DW-1:0] v_r [N_FACES][3];
  logic signed [PW-1:0] m_r [N_FACES][6];
  logic signed [CW-1:0] c_r [N_FACES][3];
  logic        [SQW-1:0] sq_r [N_FACES][3];
  logic        [SUMW-1:0] sum_r [N_FACES];
  logic        [CW-1:0] mag [N_FACES][3];

  always_comb begin
    for (int f = 0; f < N_FACES; f++) begin
      for (int k = 0; k < 3; k++) begin
        mag[f][k] = c_r[f][k][CW-1] ? CW'(-c_r[f][k]) : CW'(c_r[f][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < 5; s++) vld_r[s] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int s = 1; s < 5; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int f = 0; f < N_FACES; f++) begin
        for (int k = 0; k < 3; k++) begin
          u_r[f][k] <= DW'(pts[(f+1)%N_VERTS][k]) - DW'(pts[f][k]);
          v_r[f][k] <= DW'(pts[(f+2)%N_VERTS][k]) - DW'(pts[f][k]);
        end
        m_r[f][0] <= PW'(u_r[f][1]) * PW'(v_r[f][2]);
        m_r[f][1] <= PW'(u_r[f][2]) * PW'(v_r[f][1]);
        m_r[f][2] <= PW'(u_r[f][2]) * PW'(v_r[f][0]);
        m_r[f][3] <= PW'(u_r[f][0]) * PW'(v_r[f][2]);
        m_r[f][4] <= PW'(u_r[f][0]) * PW'(v_r[f][1]);
        m_r[f][5] <= PW'(u_r[f][1]) * PW'(v_r[f][0]);
        for (int k = 0; k < 3; k++) begin
          c_r[f][k] <= CW'(m_r[f][2*k]) - CW'(m_r[f][2*k+1]);
          sq_r[f][k] <= SQW'(mag[f][k]) * SQW'(mag[f][k]);
        end
        sum_r[f] <= SUMW'(sq_r[f][0]) + SUMW'(sq_r[f][1]) + SUMW'(sq_r[f][2]);
      end
    end
  end

  assign out_vld = vld_r[4];
  always_comb begin
    for (int f = 0; f < N_FACES; f++) norm2[f] = sum_r[f];
  end
endmodule

// ----- design/tmfa_sqrt.sv -----
`timescale 1ns / 1ps
module tmfa_sqrt
  import tmfa_pkg::*;
#(
  parameter int SUMW  = 2 * (2 * (COORD_BITS_DEF + 1) + 1) + 2,
  parameter int ROOTW = SUMW / 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [SUMW-1:0]  n_in [N_FACES],
  output logic             out_vld,
  output logic [ROOTW-1:0] root [N_FACES]
);
  localparam int RMW = ROOTW + 2;

  logic             vld_r  [ROOTW];
  logic [SUMW-1:0]  n_r    [ROOTW][N_FACES];
  logic [RMW-1:0]   rem_r  [ROOTW][N_FACES];
  logic [ROOTW-1:0] root_r [ROOTW][N_FACES];

  logic [SUMW-1:0]  n_nxt    [ROOTW][N_FACES];
  logic [RMW-1:0]   rem_nxt  [ROOTW][N_FACES];
  logic [ROOTW-1:0] root_nxt [ROOTW][N_FACES];

  // one root bit per stage: bring down two bits, try (root<<2)|1
  always_comb begin
    logic [SUMW-1:0]  n_cur;
    logic [RMW-1:0]   rem_cur;
    logic [ROOTW-1:0] root_cur;
    logic [RMW-1:0]   r2;
    logic [RMW-1:0]   trial;
    for (int s = 0; s < ROOTW; s++) begin
      for (int f = 0; f < N_FACES; f++) begin
        if (s == 0) begin
          n_cur    = n_in[f];
          rem_cur  = '0;
          root_cur = '0;
        end else begin
          n_cur    = n_r[s-1][f];
          rem_cur  = rem_r[s-1][f];
          root_cur = root_r[s-1][f];
        end
        r2    = {rem_cur[RMW-3:0], n_cur[SUMW-1:SUMW-2]};
        trial = {root_cur, 2'b01};
        n_nxt[s][f] = {n_cur[SUMW-3:0], 2'b00};
        if (r2 >= trial) begin
          rem_nxt[s][f]  = r2 - trial;
          root_nxt[s][f] = {root_cur[ROOTW-2:0], 1'b1};
        end else begin
          rem_nxt[s][f]  = r2;
          root_nxt[s][f] = {root_cur[ROOTW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < ROOTW; s++) vld_r[s] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int s = 1; s < ROOTW; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r    <= n_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign out_vld = vld_r[ROOTW-1];
  always_comb begin
    for (int f = 0; f < N_FACES; f++) root[f] = root_r[ROOTW-1][f];
  end
endmodule

// ----- design/tmfa_min.sv -----
`timescale 1ns / 1ps
module tmfa_min
  import tmfa_pkg::*;
#(
  parameter int ROOTW = 2 * COORD_BITS_DEF + 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [ROOTW-1:0]     root [N_FACES],
  input  logic [AREA_BITS-1:0] tol,
  output logic                 out_vld,
  output logic [AREA_BITS-1:0] best
);
  localparam int RW = (ROOTW > AREA_BITS) ? ROOTW : AREA_BITS;

  logic [AREA_BITS-1:0] area [N_FACES];
  logic                 vld_r  [3];
  logic [AREA_BITS-1:0] best_r [3];
  logic [AREA_BITS-1:0] a2_r;
  logic [AREA_BITS-1:0] a3_r [2];

  function automatic logic [AREA_BITS-1:0] pick(input logic [AREA_BITS-1:0] cur_best,
                                                 input logic [AREA_BITS-1:0] face,
                                                 input logic [AREA_BITS-1:0] margin);
    logic [AREA_BITS:0] lim;
    lim = {1'b0, face} + {1'b0, margin};
    return ({1'b0, cur_best} > lim) ? face : cur_best;
  endfunction

  always_comb begin
    logic [RW-1:0] ext;
    for (int f = 0; f < N_FACES; f++) begin
      ext = RW'(root[f]);
      area[f] = (ext > RW'(AREA_MAX)) ? AREA_MAX : ext[AREA_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < 3; s++) vld_r[s] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
      vld_r[1] <= vld_r[0];
      vld_r[2] <= vld_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      best_r[0] <= pick(area[0], area[1], tol);
      a2_r      <= area[2];
      a3_r[0]   <= area[3];
      best_r[1] <= pick(best_r[0], a2_r, tol);
      a3_r[1]   <= a3_r[0];
      best_r[2] <= pick(best_r[1], a3_r[1], tol);
    end
  end

  assign out_vld = vld_r[2];
  assign best    = best_r[2];
endmodule

// ----- design/tmfa_checker.sv -----
`timescale 1ns / 1ps
module tmfa_checker
  import tmfa_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [AREA_BITS-1:0] out_min_double_area,
  input logic                 pready
);
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");
  a_ready_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_min_double_area))
    else $error("stalled result changed");
  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");
endmodule

bind tetrahedron_min_face_area_unit tmfa_checker u_tmfa_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .out_min_double_area(out_min_double_area), .pready(pready)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

class area_scoreboard;
  logic [25:0] pending_areas[$];
  int fail_count;

  function void note_input(logic [25:0] area);
    pending_areas.push_back(area);
  endfunction

  function void check_output(logic [25:0] got);
    logic [25:0] want;
    if (pending_areas.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %0d", $time, got);
      fail_count++;
    end else begin
      want = pending_areas.pop_front();
      if (want !== got) begin
        $display("%0t: min_double_area mismatch, expected %0d, actual %0d",
                 $time, want, got);
        fail_count++;
      end
    end
  endfunction
endclass

module tb_top;
  import tmfa_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int LATENCY = 5 + (2 * CB + 4) + 3;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CB-1:0] crd[12];
  logic out_valid;
  logic out_ready = 1'b0;
  logic [AREA_BITS-1:0] out_min_double_area;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  area_scoreboard sb;
  logic [25:0] tol_model;
  int send_idle_pct, recv_stall_pct;
  bit hold_off;
  int quiet_cycles;

  initial for (int i = 0; i < 12; i++) crd[i] = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tetrahedron_min_face_area_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_a_x(crd[0]), .in_a_y(crd[1]), .in_a_z(crd[2]),
    .in_b_x(crd[3]), .in_b_y(crd[4]), .in_b_z(crd[5]),
    .in_c_x(crd[6]), .in_c_y(crd[7]), .in_c_z(crd[8]),
    .in_d_x(crd[9]), .in_d_y(crd[10]), .in_d_z(crd[11]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_min_double_area(out_min_double_area),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  function automatic logic [63:0] isqrt(logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [25:0] face_double_area(int p, int q, int r);
    longint ux, uy, uz, vx, vy, vz, cx, cy, cz;
    logic [63:0] s;
    ux = crd[q*3] - crd[p*3];
    uy = crd[q*3+1] - crd[p*3+1];
    uz = crd[q*3+2] - crd[p*3+2];
    vx = crd[r*3] - crd[p*3];
    vy = crd[r*3+1] - crd[p*3+1];
    vz = crd[r*3+2] - crd[p*3+2];
    cx = uy * vz - uz * vy;
    cy = uz * vx - ux * vz;
    cz = ux * vy - uy * vx;
    // sums stay far below 2^64 at 12-bit coordinates
    s = isqrt(cx * cx + cy * cy + cz * cz);
    return (s > AREA_MAX) ? AREA_MAX : s[25:0];
  endfunction

  function automatic logic [25:0] min_face_area();
    logic [25:0] best, cur;
    best = face_double_area(0, 1, 2);
    for (int i = 1; i < 4; i++) begin
      cur = face_double_area(i, (i + 1) % 4, (i + 2) % 4);
      if ({1'b0, best} > {1'b0, cur} + {1'b0, tol_model}) best = cur;
    end
    return best;
  endfunction

  task automatic write_tolerance(logic [31:0] val, logic [ADDR_BITS-1:0] addr);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr[ADDR_BITS-1:2] == 0 && addr[2] == REG_TOLERANCE) tol_model = val[25:0];
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send_item(bit use_idle);
    logic [25:0] want;
    @(negedge clk);
    while (use_idle && $urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    #0 want = min_face_area();
    sb.note_input(want);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // back-to-back send: keeps valid high across items unless a random idle gap is drawn
  task automatic send_burst(int n, int mode);
    for (int k = 0; k < n; k++) begin
      fill_coords(mode);
      in_valid <= 1'b1;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      sb.note_input(min_face_area());
      @(negedge clk);
      if (k < n - 1 && send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
        in_valid <= 1'b0;
        do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
      end
    end
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic fill_coords(int mode);
    int base;
    for (int i = 0; i < 12; i++) crd[i] = CB'($urandom);
    case (mode)
      1: for (int i = 0; i < 12; i++) crd[i] = CB'(int'($urandom_range(15)) - 8);
      2: begin
        // collinear or coincident vertices
        base = $urandom_range(3);
        for (int k = 0; k < 3; k++)
          crd[((base + 1) % 4) * 3 + k] = crd[base * 3 + k];
      end
      3: for (int i = 0; i < 12; i++) crd[i] = $urandom_range(1) ? 12'sh7ff : 12'sh800;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (sb.pending_areas.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_output(out_min_double_area);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [25:0] tols[5];
    sb = new();
    tol_model = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 0;
    tols = '{26'd0, 26'h3ffffff, 26'd1, 26'd500, 26'd20000};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, degenerate and tiny tetrahedra
    for (int i = 0; i < 12; i++) crd[i] = '0;
    send_item(0);
    for (int i = 0; i < 12; i++) crd[i] = 12'sh7ff;
    send_item(0);
    for (int i = 0; i < 12; i++) crd[i] = (i % 3 == (i / 3) % 3) ? 12'sh7ff : 12'sh800;
    send_item(0);
    for (int i = 0; i < 12; i++) crd[i] = '0;
    crd[3] = 12'sh7ff; crd[7] = 12'sh7ff; crd[11] = 12'sh7ff;
    send_item(0);
    crd[3] = 12'sh800; crd[7] = 12'sh800; crd[11] = 12'sh800;
    send_item(0);
    for (int k = 0; k < 12; k++) begin
      fill_coords(k % 4);
      send_item(0);
    end
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      write_tolerance({6'h3f, tols[ph]}, 3'd0);
      // write to an unused address must be ignored
      if (ph == 2) write_tolerance(32'h12345, 3'd4);
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 75; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 75; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      if (ph == 4) begin send_idle_pct = 0; recv_stall_pct = 0; end
      @(negedge clk);
      if (ph == 0) begin
        fork
          begin hold_off = 1; repeat (200) @(negedge clk); hold_off = 0; end
          send_burst(150, $urandom_range(3));
        join
      end else begin
        for (int b = 0; b < 15; b++) send_burst(10, $urandom_range(3));
      end
      wait_drained();
    end

    if (sb.fail_count == 0 && sb.pending_areas.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
